>>> rtl/pillar_chain_min_cost_dp_assert.svh
// Assertion macros for the pillar chain cost solver.
`ifndef PILLAR_CHAIN_MIN_COST_DP_ASSERT_SVH
`define PILLAR_CHAIN_MIN_COST_DP_ASSERT_SVH
`define PCD_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define PCD_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

>>> rtl/pcd_pkg.sv
// Package with widths, types and constants of the pillar chain cost solver.
`timescale 1ns / 1ps
`default_nettype none
package pcd_pkg;
  localparam int MaxPillars = 1024;
  localparam int IdxW = $clog2(MaxPillars);
  localparam int CntW = IdxW + 1;
  localparam int HW = 20;
  localparam int RcW = 21;
  localparam int PW = 32;
  localparam int CW = 44;
  localparam int DW = HW + 1;
  localparam int SqW = 2 * HW;

  typedef enum logic [2:0] {
    StLoad,
    StOuter,
    StRead,
    StSquare,
    StSum,
    StWrite,
    StOut
  } state_e;
endpackage
`default_nettype wire

>>> rtl/pcd_mac.sv
// Shared arithmetic unit: registered square of a height difference.
`timescale 1ns / 1ps
`default_nettype none
module pcd_mac
  import pcd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic [HW-1:0]        hi_i,
  input  wire logic [HW-1:0]        hj_i,
  output logic      [SqW-1:0]       sq_o
);
  logic signed [DW-1:0] diff;
  logic [HW-1:0] mag;
  logic [SqW-1:0] sq_q;

  assign diff = $signed({1'b0, hi_i}) - $signed({1'b0, hj_i});
  assign mag = diff[DW-1] ? HW'(-diff) : diff[HW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= mag * mag;
    end
  end

  assign sq_o = sq_q;
endmodule
`default_nettype wire

>>> rtl/pillar_chain_min_cost_dp.sv
// Pillar chain solver: loads pillars one per cycle and then solves the chain cost.
// Pillars load at one request per cycle. A request with is_last starts the solve, which
// walks every pair j < i of stored pillars through one shared squaring unit and one adder,
// reading each pair, squaring, summing and then writing each pillar's best cost once its pairs
// are done; stall_o stays high until the result is taken. Pillars beyond 1024 are dropped.
`timescale 1ns / 1ps
`default_nettype none
module pillar_chain_min_cost_dp
  import pcd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       stall_o,
  input  wire logic [HW-1:0]         pillar_height_i,
  input  wire logic signed [RcW-1:0] removal_cost_i,
  input  wire logic                  is_last_i,
  output logic                       valid_o,
  input  wire logic                  stall_i,
  output logic signed [CW-1:0]       min_total_cost_o
);
  logic [HW-1:0] h_mem [MaxPillars];
  logic [PW-1:0] p_mem [MaxPillars];
  logic [CW-1:0] c_mem [MaxPillars];

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] i_q, i_d, j_q, j_d;
  logic [PW-1:0] run_q;
  logic signed [CW-1:0] best_q, best_d, res_q, res_d;
  logic [HW-1:0] hi_q, hj_q;
  logic [PW-1:0] pim1_q, pj_q;
  logic [CW-1:0] cj_q;
  logic [SqW-1:0] sq;
  logic signed [CW-1:0] cand;
  logic acc, store;
  logic [PW-1:0] pnew;

  assign acc = valid_i && !stall_o;
  assign store = acc && (cnt_q < CntW'(MaxPillars));
  assign pnew = (cnt_q == '0 ? '0 : run_q) + PW'(removal_cost_i);

  always_ff @(posedge clk_i) begin
    if (store) begin
      h_mem[cnt_q[IdxW-1:0]] <= pillar_height_i;
      p_mem[cnt_q[IdxW-1:0]] <= pnew;
    end
    if (state_q == StOuter) begin
      hi_q <= h_mem[i_q[IdxW-1:0]];
      pim1_q <= p_mem[IdxW'(i_q - 1'b1)];
    end
    if (state_q == StRead) begin
      hj_q <= h_mem[j_q[IdxW-1:0]];
      pj_q <= p_mem[j_q[IdxW-1:0]];
      cj_q <= (j_q == '0) ? '0 : c_mem[j_q[IdxW-1:0]];
    end
    if (state_q == StWrite) begin
      c_mem[i_q[IdxW-1:0]] <= best_q;
    end
    if (store) begin
      run_q <= pnew;
    end
  end

  pcd_mac u_mac (
    .clk_i(clk_i),
    .en_i (state_q == StSquare),
    .hi_i (hi_q),
    .hj_i (hj_q),
    .sq_o (sq)
  );

  assign cand = $signed(cj_q) + CW'($signed(pim1_q)) - CW'($signed(pj_q))
              + $signed({{(CW-SqW){1'b0}}, sq});

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    i_d = i_q;
    j_d = j_q;
    best_d = best_q;
    res_d = res_q;
    stall_o = (state_q != StLoad);
    unique case (state_q)
      StLoad: begin
        if (store) cnt_d = cnt_q + 1'b1;
        if (acc && is_last_i) begin
          cnt_d = store ? cnt_q + 1'b1 : cnt_q;
          i_d = CntW'(1);
          state_d = StOuter;
        end
      end
      StOuter: begin
        if (i_q >= cnt_q) begin
          state_d = StOut;
          res_d = (cnt_q == CntW'(1)) ? '0 : best_q;
        end else begin
          j_d = '0;
          state_d = StRead;
        end
      end
      StRead: state_d = StSquare;
      StSquare: state_d = StSum;
      StSum: begin
        if (j_q == '0 || cand < best_q) best_d = cand;
        if (j_q + 1'b1 == i_q) begin
          state_d = StWrite;
        end else begin
          j_d = j_q + 1'b1;
          state_d = StRead;
        end
      end
      StWrite: begin
        i_d = i_q + 1'b1;
        state_d = StOuter;
      end
      StOut: begin
        if (!stall_i) begin
          cnt_d = '0;
          state_d = StLoad;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d;
    j_q <= j_d;
    best_q <= best_d;
    res_q <= res_d;
  end

  assign valid_o = (state_q == StOut);
  assign min_total_cost_o = res_q;
endmodule
`default_nettype wire

>>> rtl/pcd_checker.sv
// Port-level checker for the pillar chain solver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "pillar_chain_min_cost_dp_assert.svh"
module pcd_checker
  import pcd_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic valid_i,
  input wire logic stall_o,
  input wire logic is_last_i,
  input wire logic valid_o,
  input wire logic stall_i,
  input wire logic [CW-1:0] min_total_cost_o
);
  `PCD_ASSERT_NXT(a_last_blocks, clk_i, rst_ni, valid_i && !stall_o && is_last_i, stall_o,
                  "The solver took a request while solving.")
  `PCD_ASSERT_IMP(a_out_blocks, clk_i, rst_ni, valid_o, stall_o,
                  "A result is shown while requests are taken.")
  `PCD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, valid_o && stall_i,
                  valid_o && $stable(min_total_cost_o), "A stalled result changed.")
  `PCD_ASSERT_NXT(a_no_dup, clk_i, rst_ni, valid_o && !stall_i, !valid_o,
                  "A result was repeated.")
endmodule
bind pillar_chain_min_cost_dp pcd_checker u_pcd_checker (.*);
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the pillar chain minimum cost solver.
`timescale 1ns / 1ps
module tb_top;
  import pcd_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  valid_i = 1'b0;
  logic                  stall_o;
  logic [HW-1:0]         pillar_height_i = '0;
  logic signed [RcW-1:0] removal_cost_i = '0;
  logic                  is_last_i = 1'b0;
  logic                  valid_o;
  logic                  stall_i = 1'b0;
  logic signed [CW-1:0]  min_total_cost_o;

  longint chain_height[MaxPillars];
  longint chain_prefix[MaxPillars];
  longint chain_best[MaxPillars];
  int     chain_len = 0;
  logic signed [CW-1:0] cost_queue[$];
  int     mismatches = 0;
  int     tx_idle_pct = 0;
  int     rx_idle_pct = 0;

  pillar_chain_min_cost_dp DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(valid_i), .stall_o(stall_o),
    .pillar_height_i(pillar_height_i), .removal_cost_i(removal_cost_i),
    .is_last_i(is_last_i), .valid_o(valid_o), .stall_i(stall_i),
    .min_total_cost_o(min_total_cost_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic signed [CW-1:0] solve_chain_cost(int n);
    longint best, c, dh;
    chain_best[0] = 0;
    for (int i = 1; i < n; i++) begin
      best = 0;
      for (int j = 0; j < i; j++) begin
        dh = chain_height[i] - chain_height[j];
        c = chain_best[j] + chain_prefix[i-1] - chain_prefix[j] + dh * dh;
        if (j == 0 || c < best) best = c;
      end
      chain_best[i] = best;
    end
    return chain_best[n-1][CW-1:0];
  endfunction

  task automatic accept_pillar(logic [HW-1:0] h, logic signed [RcW-1:0] rc, logic last);
    if (chain_len < MaxPillars) begin
      chain_height[chain_len] = longint'(h);
      chain_prefix[chain_len] = (chain_len == 0 ? 0 : chain_prefix[chain_len-1]) + longint'(rc);
      chain_len++;
    end
    if (last) begin
      cost_queue.push_back(solve_chain_cost(chain_len));
      chain_len = 0;
    end
  endtask

  task automatic send_pillar(logic [HW-1:0] h, logic signed [RcW-1:0] rc, logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i         <= 1'b1;
    pillar_height_i <= h;
    removal_cost_i  <= rc;
    is_last_i       <= last;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    accept_pillar(h, rc, last);
  endtask

  task automatic finish_sending();
    valid_i <= 1'b0;
    while (cost_queue.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    stall_i <= ($urandom_range(99) < rx_idle_pct);
    if (rst_ni && valid_o && !stall_i) begin
      if (cost_queue.size() == 0) begin
        $error("min_total_cost: unexpected result %0d", min_total_cost_o);
        mismatches++;
      end else begin
        if (min_total_cost_o !== cost_queue[0]) begin
          $error("min_total_cost: expected %0d, actual %0d", cost_queue[0], min_total_cost_o);
          mismatches++;
        end
        void'(cost_queue.pop_front());
      end
    end
  end

  task automatic test_extremes();
    send_pillar(20'hFFFFF, 21'sh0FFFFF, 1'b1);
    send_pillar(20'h00000, -21'sh100000, 1'b1);
    send_pillar(20'h00000, -21'sh100000, 1'b0);
    send_pillar(20'hFFFFF, 21'sh0FFFFF, 1'b1);
    send_pillar(20'hFFFFF, 21'sh0FFFFF, 1'b0);
    send_pillar(20'h00000, 21'sh0FFFFF, 1'b1);
    send_pillar(20'h00000, -21'sh100000, 1'b0);
    send_pillar(20'h00000, -21'sh100000, 1'b0);
    send_pillar(20'h00000, -21'sh100000, 1'b0);
    send_pillar(20'h00000, 21'sh000000, 1'b1);
    send_pillar(20'h00005, 21'sh000003, 1'b0);
    send_pillar(20'h00001, 21'sh0FFFFF, 1'b0);
    send_pillar(20'h00009, 21'sh000002, 1'b0);
    send_pillar(20'hFFFFF, -21'sh000001, 1'b0);
    send_pillar(20'h00008, 21'sh000007, 1'b1);
    send_pillar(20'h55555, 21'sh0AAAAA, 1'b0);
    send_pillar(20'hAAAAA, -21'sh055556, 1'b1);
    finish_sending();
  endtask

  // The chain overflows the store, so the trailing pillars are dropped.
  task automatic test_store_full();
    for (int k = 0; k < MaxPillars + 6; k++)
      send_pillar(HW'($urandom()), RcW'($urandom()), k == MaxPillars + 5);
    finish_sending();
    send_pillar(20'h00003, 21'sh000001, 1'b0);
    send_pillar(20'h00007, 21'sh000001, 1'b1);
    finish_sending();
  endtask

  task automatic test_random_chains(int n_items);
    logic [HW-1:0] h;
    for (int k = 0; k < n_items; k++) begin
      h = ($urandom_range(1) == 0) ? HW'($urandom()) : HW'($urandom_range(64));
      send_pillar(h, RcW'($urandom()), ($urandom_range(5) == 0) || (k == n_items - 1));
    end
    finish_sending();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_pct = 11;
    rx_idle_pct = 62;
    test_extremes();
    test_random_chains(90);
    tx_idle_pct = 62;
    rx_idle_pct = 11;
    test_random_chains(90);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_store_full();
    test_random_chains(90);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && cost_queue.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
